/* rtl/core/tmrtbl_pkg.sv */
// shared types and constants of the interval timer slot table
// controller commands, datapath status, slot entry layout, result kinds
// no dependencies
package tmrtbl_pkg;

	// stream payload widths, padded to whole bytes
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 56;

	localparam logic [31:0] US_PER_MS = 32'd1000;
	localparam logic [31:0] NO_DUE    = 32'hffff_ffff;
	localparam logic [15:0] TOL_RESET = 16'd1000;

	// request selector carried in the input tuser
	typedef enum logic [1:0] {
		OP_REGISTER = 2'd0,
		OP_CANCEL   = 2'd1,
		OP_TICK     = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	// result kind carried in the output tuser
	typedef enum logic [2:0] {
		KIND_REGD   = 3'd0,
		KIND_FULL   = 3'd1,
		KIND_FIRED  = 3'd2,
		KIND_DONE   = 3'd3,
		KIND_CANCEL = 3'd4
	} kind_t;

	// one slot of the timer memory
	typedef struct packed {
		logic [31:0] step_us;
		logic [31:0] due_us;
		logic [15:0] count;
		logic        rep_forever;
	} slot_entry_t;

	// controller to datapath
	typedef struct packed {
		logic  load_in;
		logic  idx_inc;
		logic  step_mul;
		logic  reg_write;
		logic  cancel;
		logic  eval_load;
		logic  fire;
		logic  div_start;
		logic  adj;
		logic  wb;
		logic  cmp;
		logic  emit;
		kind_t emit_kind;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic used_cur;
		logic idx_last;
		logic out_free;
		logic fire_hit;
		logic fire_final;
		logic catch_up;
		logic div_busy;
	} ctrl_sts_t;

	// modular time order: a strictly before b
	function automatic logic is_before(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = b - a;
		return (d != 32'd0) && !d[31];
	endfunction

endpackage

/* rtl/core/tmrtbl_ctrl.sv */
// controller state machine of the timer slot table
// sequences register, cancel and tick requests over the datapath
// depends on tmrtbl_pkg
module tmrtbl_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  tmrtbl_pkg::op_t       in_op,
	output logic                  in_ready,
	input  tmrtbl_pkg::ctrl_sts_t sts,
	output tmrtbl_pkg::ctrl_cmd_t cmd
);
	import tmrtbl_pkg::*;

	typedef enum logic [14:0] {
		ST_IDLE      = 15'b000000000000001,
		ST_REG_SCAN  = 15'b000000000000010,
		ST_REG_MUL   = 15'b000000000000100,
		ST_REG_WRITE = 15'b000000000001000,
		ST_REG_FULL  = 15'b000000000010000,
		ST_CANCEL    = 15'b000000000100000,
		ST_T_READ    = 15'b000000001000000,
		ST_T_EVAL    = 15'b000000010000000,
		ST_T_FIRE    = 15'b000000100000000,
		ST_T_CHK     = 15'b000001000000000,
		ST_T_DIV     = 15'b000010000000000,
		ST_T_WB      = 15'b000100000000000,
		ST_T_CMP     = 15'b001000000000000,
		ST_T_NEXT    = 15'b010000000000000,
		ST_T_DONE    = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.emit_kind = KIND_REGD;
		in_ready      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					case (in_op)
						OP_REGISTER: state_d = ST_REG_SCAN;
						OP_CANCEL:   state_d = ST_CANCEL;
						OP_TICK:     state_d = ST_T_READ;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			// walk the used bits for the lowest free slot
			ST_REG_SCAN: begin
				if (!sts.used_cur) begin
					state_d = ST_REG_MUL;
				end else if (sts.idx_last) begin
					state_d = ST_REG_FULL;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_REG_MUL: begin
				cmd.step_mul = 1'b1;
				state_d      = ST_REG_WRITE;
			end
			ST_REG_WRITE: begin
				if (sts.out_free) begin
					cmd.reg_write = 1'b1;
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_REGD;
					state_d       = ST_IDLE;
				end
			end
			ST_REG_FULL: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_FULL;
					state_d       = ST_IDLE;
				end
			end
			ST_CANCEL: begin
				if (sts.out_free) begin
					cmd.cancel    = 1'b1;
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_CANCEL;
					state_d       = ST_IDLE;
				end
			end
			// tick: skip free slots, read live ones
			ST_T_READ: begin
				if (sts.used_cur) begin
					state_d = ST_T_EVAL;
				end else if (sts.idx_last) begin
					state_d = ST_T_DONE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_T_EVAL: begin
				cmd.eval_load = 1'b1;
				state_d       = sts.fire_hit ? ST_T_FIRE : ST_T_CMP;
			end
			ST_T_FIRE: begin
				if (sts.out_free) begin
					cmd.fire      = 1'b1;
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_FIRED;
					state_d       = sts.fire_final ? ST_T_NEXT : ST_T_CHK;
				end
			end
			ST_T_CHK: begin
				if (sts.catch_up) begin
					cmd.div_start = 1'b1;
					state_d       = ST_T_DIV;
				end else begin
					state_d = ST_T_WB;
				end
			end
			ST_T_DIV: begin
				if (!sts.div_busy) begin
					cmd.adj = 1'b1;
					state_d = ST_T_WB;
				end
			end
			ST_T_WB: begin
				cmd.wb  = 1'b1;
				state_d = ST_T_CMP;
			end
			ST_T_CMP: begin
				cmd.cmp = 1'b1;
				state_d = ST_T_NEXT;
			end
			ST_T_NEXT: begin
				if (sts.idx_last) begin
					state_d = ST_T_DONE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_T_READ;
				end
			end
			ST_T_DONE: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_DONE;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/tmrtbl_rem.sv */
// bit-serial remainder unit, one quotient bit per cycle
// restoring scheme over 32-bit operands, no dependencies
module tmrtbl_rem (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] rem
);
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] dvd_q;
	logic [31:0] dsr_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	// one restoring step
	always_comb begin
		shifted = {rem_q, dvd_q[31]};
		diff    = shifted - {1'b0, dsr_q};
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (cnt_q != 6'd0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	// partial remainder and dividend shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != 6'd0) begin
			rem_q <= diff[32] ? shifted[31:0] : diff[31:0];
			dvd_q <= {dvd_q[30:0], 1'b0};
		end
	end

	assign busy = (cnt_q != 6'd0);
	assign rem  = rem_q;

endmodule

/* rtl/core/tmrtbl_dp.sv */
// datapath of the timer slot table: slot memory, used bits, working registers,
// tolerance register, catch-up remainder unit and result register
// depends on tmrtbl_pkg and tmrtbl_rem
module tmrtbl_dp #(
	parameter int TIMER_SLOTS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [tmrtbl_pkg::IN_DATA_W-1:0]     in_data,
	input  logic                                 cfg_we,
	input  logic [15:0]                          cfg_wdata,
	input  tmrtbl_pkg::ctrl_cmd_t                cmd,
	output tmrtbl_pkg::ctrl_sts_t                sts,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic [tmrtbl_pkg::OUT_DATA_W-1:0]    out_data,
	output logic [2:0]                           out_kind,
	output logic                                 out_last
);
	import tmrtbl_pkg::*;

	localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TIMER_SLOTS - 1);

	// input beat fields
	logic [31:0] in_now;
	logic [21:0] in_period;
	logic [15:0] in_count;
	logic        in_forever;
	logic [2:0]  in_sidx;

	assign in_now     = in_data[31:0];
	assign in_period  = in_data[53:32];
	assign in_count   = in_data[69:54];
	assign in_forever = in_data[70];
	assign in_sidx    = in_data[73:71];

	logic [15:0]       tol_q;
	logic [31:0]       now_q, target_q;
	logic [21:0]       period_q;
	logic [15:0]       count_q;
	logic              forever_q;
	logic [2:0]        sidx_q;
	logic [SLOT_W-1:0] idx_q;
	logic [TIMER_SLOTS-1:0] used_q;

	slot_entry_t slot_mem_q [TIMER_SLOTS];
	slot_entry_t rd_q;
	slot_entry_t wr_data;
	logic        wr_en;

	logic [31:0] step_w_q, due_w_q;
	logic [15:0] cnt_w_q;
	logic        fe_w_q;

	logic        found_q;
	logic [31:0] best_due_q, best_dist_q;

	logic [21:0] per_eff;
	logic [15:0] cnt_eff;
	logic        final_fire;
	logic        cancel_hit;
	logic [31:0] due_dist;
	logic        better;
	logic        div_busy;
	logic [31:0] div_rem;

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			now_q     <= in_now;
			target_q  <= in_now + 32'(tol_q);
			period_q  <= in_period;
			count_q   <= in_count;
			forever_q <= in_forever;
			sidx_q    <= in_sidx;
		end
	end

	// zero period and zero count arm as one
	assign per_eff    = (period_q == 22'd0) ? 22'd1 : period_q;
	assign cnt_eff    = (count_q == 16'd0) ? 16'd1 : count_q;
	assign final_fire = !fe_w_q && (cnt_w_q <= 16'd1);
	assign cancel_hit = (32'(sidx_q) < 32'(TIMER_SLOTS));

	// slot index counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load_in) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + SLOT_W'(1);
		end
	end

	// used bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.reg_write) begin
			used_q[idx_q] <= 1'b1;
		end else if (cmd.cancel && cancel_hit) begin
			used_q[SLOT_W'(sidx_q)] <= 1'b0;
		end else if (cmd.fire && final_fire) begin
			used_q[idx_q] <= 1'b0;
		end
	end

	// slot memory write port
	always_comb begin
		wr_en   = cmd.reg_write | cmd.wb;
		wr_data = '{step_us: step_w_q, due_us: due_w_q, count: cnt_w_q,
			rep_forever: fe_w_q};
		if (cmd.reg_write) begin
			wr_data = '{step_us: step_w_q, due_us: now_q + step_w_q, count: cnt_eff,
				rep_forever: forever_q};
		end
	end

	// slot memory, registered read at the scan index
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem_q[idx_q] <= wr_data;
		end
		rd_q <= slot_mem_q[idx_q];
	end

	// catch-up remainder of (target - due) by the step
	tmrtbl_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (target_q - due_w_q),
		.divisor  (step_w_q),
		.busy     (div_busy),
		.rem      (div_rem)
	);

	// working copy of the slot under evaluation
	always_ff @(posedge clk) begin
		if (cmd.step_mul) begin
			step_w_q <= 32'(per_eff) * US_PER_MS;
		end else if (cmd.eval_load) begin
			step_w_q <= rd_q.step_us;
		end
		if (cmd.eval_load) begin
			due_w_q <= rd_q.due_us;
			cnt_w_q <= rd_q.count;
			fe_w_q  <= rd_q.rep_forever;
		end else if (cmd.fire) begin
			due_w_q <= due_w_q + step_w_q;
			if (!fe_w_q) begin
				cnt_w_q <= cnt_w_q - 16'd1;
			end
		end else if (cmd.adj) begin
			// land on the first period boundary not before the target
			due_w_q <= (div_rem == 32'd0) ? target_q : target_q + (step_w_q - div_rem);
		end
	end

	// earliest due time tracking
	assign due_dist = due_w_q - now_q;
	assign better   = !found_q || (due_dist < best_dist_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.load_in) begin
			found_q <= 1'b0;
		end else if (cmd.cmp) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp && better) begin
			best_dist_q <= due_dist;
			best_due_q  <= due_w_q;
		end
	end

	// result register
	logic        out_valid_q;
	kind_t       kind_q;
	logic [2:0]  slot_q, slot_d;
	logic [15:0] left_q, left_d;
	logic        ffe_q, ffe_d;
	logic [31:0] early_q, early_d;
	logic        dfound_q, dfound_d;
	logic        last_q, last_d;

	always_comb begin
		slot_d   = 3'd0;
		left_d   = 16'd0;
		ffe_d    = 1'b0;
		early_d  = 32'd0;
		dfound_d = 1'b0;
		last_d   = 1'b1;
		case (cmd.emit_kind)
			KIND_REGD: begin
				slot_d = 3'(idx_q);
			end
			KIND_FULL: begin
				slot_d = 3'd0;
			end
			KIND_FIRED: begin
				slot_d = 3'(idx_q);
				left_d = fe_w_q ? 16'd0 : cnt_w_q - 16'd1;
				ffe_d  = fe_w_q;
				last_d = 1'b0;
			end
			KIND_DONE: begin
				early_d  = found_q ? best_due_q : NO_DUE;
				dfound_d = found_q;
			end
			KIND_CANCEL: begin
				slot_d = sidx_q;
			end
			default: begin
				slot_d = 3'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q   <= cmd.emit_kind;
			slot_q   <= slot_d;
			left_q   <= left_d;
			ffe_q    <= ffe_d;
			early_q  <= early_d;
			dfound_q <= dfound_d;
			last_q   <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {3'd0, dfound_q, early_q, ffe_q, left_q, slot_q};
	assign out_kind  = 3'(kind_q);
	assign out_last  = last_q;

	// status to the controller
	always_comb begin
		sts            = '0;
		sts.used_cur   = used_q[idx_q];
		sts.idx_last   = (idx_q == LAST_IDX);
		sts.out_free   = !out_valid_q || out_ready;
		sts.fire_hit   = !is_before(target_q, rd_q.due_us);
		sts.fire_final = final_fire;
		sts.catch_up   = is_before(due_w_q, target_q);
		sts.div_busy   = div_busy;
	end

endmodule

/* rtl/core/multi_slot_interval_timer_table_core.sv */
// top level of the interval timer slot table
// joins the controller and the datapath to the stream and configuration ports
// depends on tmrtbl_pkg, tmrtbl_ctrl, tmrtbl_dp
//
// A table of TIMER_SLOTS interval timers, one request per input beat, one at a time.
// A register request (tuser 0) takes the lowest free slot and answers with one beat
// once the scan reaches it past the used slots. A cancel (tuser 1) answers with one
// beat; tuser 3 is taken and dropped. A tick (tuser 2) scans every slot through
// the single port of the slot memory: it skips a free slot and reads and evaluates a
// live one; a slot that fires for the last time moves on, one that fires and stays armed
// is checked and written back, and it waits on the bit-serial remainder unit, which finds
// the catch-up point, when a fired timer has fallen more than one period behind. The tick
// ends with one beat that carries the earliest due time. An output register holds each
// result beat, so a new request is taken while the final beat of the last one waits; a
// stalled master side holds the scan at its next beat.
module multi_slot_interval_timer_table_core #(
	parameter int TIMER_SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// request beat
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // now_us, period_ms, repeat_count, run_forever, slot_index
	input  logic [1:0]  s_tuser,   // op
	// result beat
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // slot, firings_left, fires_forever, earliest_due_us, due_found
	output logic [2:0]  m_tuser,   // kind
	output logic        m_tlast,
	// tolerance register
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import tmrtbl_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	// sequencer
	tmrtbl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (op_t'(s_tuser)),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table storage and arithmetic
	tmrtbl_dp #(
		.TIMER_SLOTS (TIMER_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.out_kind  (m_tuser),
		.out_last  (m_tlast)
	);

endmodule
